// ===== src/ipv4dq_pkg.sv =====
// Shared types and constants for the dotted-quad IPv4 validator.
// Used by the front classifier, the character queue, the back checker and the top.
package ipv4dq_pkg;

  localparam logic [7:0] SepChar = 8'h2E;
  localparam logic [7:0] DigitLo = 8'h30;
  localparam logic [7:0] DigitHi = 8'h39;

  localparam logic [2:0] PeriodsWanted = 3'd3;
  localparam logic [2:0] MaxFieldLen = 3'd3;
  localparam logic [2:0] SatCount = 3'd4;
  localparam logic [9:0] MaxOctet = 10'd255;
  localparam logic [9:0] MinFirst = 10'd1;

  localparam logic [1:0] StatusValid = 2'd0;
  localparam logic [1:0] StatusPeriods = 2'd1;
  localparam logic [1:0] StatusField = 2'd2;
  localparam logic [1:0] StatusNonDigit = 2'd3;

  localparam int QDepth = 2;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    ChrPeriod = 2'd0,
    ChrDigit  = 2'd1,
    ChrOther  = 2'd2
  } chr_class_e;

  typedef struct packed {
    chr_class_e kind;
    logic [3:0] digit;
    logic       last;
  } chr_entry_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [QCntW-1:0] count;
  } q_status_t;

endpackage

// ===== src/ipv4dq_front.sv =====
// Front part: accept characters and classify them for the queue.
// Depends on ipv4dq_pkg for the entry type and character codes.
module ipv4dq_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_code_i,
  input  logic                  is_last_i,
  input  ipv4dq_pkg::q_status_t q_status_i,
  output logic                  push_o,
  output ipv4dq_pkg::chr_entry_t entry_o
);

  logic [7:0] digit_off;

  assign digit_off  = char_code_i - ipv4dq_pkg::DigitLo;
  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    entry_o.last  = is_last_i;
    entry_o.digit = digit_off[3:0];
    priority if (char_code_i == ipv4dq_pkg::SepChar) begin
      entry_o.kind = ipv4dq_pkg::ChrPeriod;
    end else if (char_code_i >= ipv4dq_pkg::DigitLo && char_code_i <= ipv4dq_pkg::DigitHi) begin
      entry_o.kind = ipv4dq_pkg::ChrDigit;
    end else begin
      entry_o.kind = ipv4dq_pkg::ChrOther;
    end
  end

endmodule

// ===== src/ipv4dq_queue.sv =====
// Short queue of classified characters between front and back.
// Depends on ipv4dq_pkg for the entry type and queue depth.
module ipv4dq_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ipv4dq_pkg::chr_entry_t push_entry_i,
  input  logic                   pop_i,
  output ipv4dq_pkg::chr_entry_t head_o,
  output ipv4dq_pkg::q_status_t  status_o
);

  ipv4dq_pkg::chr_entry_t slot_q [ipv4dq_pkg::QDepth];
  logic [ipv4dq_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ipv4dq_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ipv4dq_pkg::QCntW-1:0] count_q, count_d;

  localparam logic [ipv4dq_pkg::QPtrW-1:0] LastPtr = ipv4dq_pkg::QPtrW'(ipv4dq_pkg::QDepth - 1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == ipv4dq_pkg::QCntW'(ipv4dq_pkg::QDepth));

endmodule

// ===== src/ipv4dq_back.sv =====
// Back part: per-field checks on queued characters and the status register.
// Depends on ipv4dq_pkg for the entry type, limits and status codes.
module ipv4dq_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ipv4dq_pkg::chr_entry_t head_i,
  input  ipv4dq_pkg::q_status_t  q_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o
);

  logic [2:0] per_q, per_d, per_s;
  logic [2:0] len_q, len_d, len_s;
  logic [9:0] val_q, val_d, val_s;
  logic       len_err_q, len_err_d, len_err_s, len_err_f;
  logic       nd_err_q, nd_err_d, nd_err_s;
  logic       rng_err_q, rng_err_d, rng_err_s, rng_err_f;
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [9:0] val_next;

  assign pop_o    = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign val_next = 10'(val_q * 10'd10) + {6'b0, head_i.digit};

  always_comb begin
    // Step one: apply the character.
    per_s     = per_q;
    len_s     = len_q;
    val_s     = val_q;
    len_err_s = len_err_q;
    nd_err_s  = nd_err_q;
    rng_err_s = rng_err_q;
    unique case (head_i.kind)
      ipv4dq_pkg::ChrPeriod: begin
        if (len_q == 3'd0 || len_q > ipv4dq_pkg::MaxFieldLen) len_err_s = 1'b1;
        if (val_q > ipv4dq_pkg::MaxOctet) rng_err_s = 1'b1;
        if (per_q == 3'd0 && val_q < ipv4dq_pkg::MinFirst) rng_err_s = 1'b1;
        len_s = '0;
        val_s = '0;
        if (per_q < ipv4dq_pkg::SatCount) per_s = per_q + 3'd1;
      end
      ipv4dq_pkg::ChrDigit: begin
        if (len_q < ipv4dq_pkg::MaxFieldLen) val_s = val_next;
        if (len_q < ipv4dq_pkg::SatCount) len_s = len_q + 3'd1;
      end
      default: begin
        nd_err_s = 1'b1;
        if (len_q < ipv4dq_pkg::SatCount) len_s = len_q + 3'd1;
      end
    endcase

    // Step two: close the final field at the end of the string.
    len_err_f = len_err_s || len_s == 3'd0 || len_s > ipv4dq_pkg::MaxFieldLen;
    rng_err_f = rng_err_s || val_s > ipv4dq_pkg::MaxOctet ||
                (per_s == 3'd0 && val_s < ipv4dq_pkg::MinFirst);

    priority if (per_s != ipv4dq_pkg::PeriodsWanted) begin
      status_d = ipv4dq_pkg::StatusPeriods;
    end else if (len_err_f) begin
      status_d = ipv4dq_pkg::StatusField;
    end else if (nd_err_s) begin
      status_d = ipv4dq_pkg::StatusNonDigit;
    end else if (rng_err_f) begin
      status_d = ipv4dq_pkg::StatusField;
    end else begin
      status_d = ipv4dq_pkg::StatusValid;
    end

    per_d       = per_q;
    len_d       = len_q;
    val_d       = val_q;
    len_err_d   = len_err_q;
    nd_err_d    = nd_err_q;
    rng_err_d   = rng_err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      if (head_i.last) begin
        per_d       = '0;
        len_d       = '0;
        val_d       = '0;
        len_err_d   = 1'b0;
        nd_err_d    = 1'b0;
        rng_err_d   = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        per_d     = per_s;
        len_d     = len_s;
        val_d     = val_s;
        len_err_d = len_err_s;
        nd_err_d  = nd_err_s;
        rng_err_d = rng_err_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q       <= '0;
      len_q       <= '0;
      val_q       <= '0;
      len_err_q   <= 1'b0;
      nd_err_q    <= 1'b0;
      rng_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      per_q       <= per_d;
      len_q       <= len_d;
      val_q       <= val_d;
      len_err_q   <= len_err_d;
      nd_err_q    <= nd_err_d;
      rng_err_q   <= rng_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// ===== src/ipv4_dotted_quad_validator_top.sv =====
// Top level of the dotted-quad IPv4 validator: front, queue and back wired together.
// Depends on ipv4dq_pkg, ipv4dq_front, ipv4dq_queue and ipv4dq_back.
//
// The block checks one dotted-quad address string, sent one character per request
// with is_last_i set on the final character (no trailing newline). After the final
// character it returns one status request: 0 valid, 1 not exactly three periods,
// 2 a field that is empty, longer than three characters or out of range (first field
// 1..255, others 0..255), 3 a character that is neither a digit nor a period; the
// checks rank in that order, with field length above non-digit above range. It takes
// one character every cycle while the queue has room: the front classifies a character
// and writes it to a two-entry queue, and the back applies one queued character per
// cycle to the field counters unless a finished status waits. The status is registered
// when the back pops the final character and is held in the output register; while it
// waits, characters of the next string keep flowing until the queue fills.
module ipv4_dotted_quad_validator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o
);

  ipv4dq_pkg::q_status_t  q_status;
  ipv4dq_pkg::chr_entry_t push_entry;
  ipv4dq_pkg::chr_entry_t head;
  logic                   push;
  logic                   pop;

  // Classify the incoming character; hold off while the queue is full.
  ipv4dq_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Decouple the two sides so either can stall on its own.
  ipv4dq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // Advance the field checks and emit the status at the end of a string.
  ipv4dq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o)
  );

`ifndef SYNTHESIS
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("queue read while empty");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("queue written while full");

  a_ready_means_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_status.count == ipv4dq_pkg::QCntW'(ipv4dq_pkg::QDepth))
    else $error("input stalled with room in the queue");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !pop)
    else $error("back advanced while a status was waiting");
`endif

endmodule
